FILE: sv/rhc_pkg.sv
// Shared types, constants and the long-division step of the RGB to HSV converter.
// Has no dependencies; every other file imports it.
`default_nettype none

package rhc_pkg;

  // Depth of the queue between classification and arithmetic.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Division pipeline: one quotient bit per stage.
  localparam int unsigned SAT_STEPS = 16;
  localparam int unsigned HUE_STEPS = 12;

  // Hue constants in 1/64 degree.
  localparam logic [15:0] HUE_FULL   = 16'd23040;
  localparam logic [15:0] BASE_RED   = 16'd0;
  localparam logic [15:0] BASE_GREEN = 16'd7680;
  localparam logic [15:0] BASE_BLUE  = 16'd15360;

  // One input pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // One result item.
  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [15:0] brightness;
    logic        achromatic;
  } hsv_t;

  // Which channel holds the maximum.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // Classified pixel, as it waits in the queue.
  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] delta;
    logic       gray;
    sector_e    sector;
    logic       neg;
    logic [7:0] mag;
  } cls_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Payload of one division pipeline stage.
  typedef struct packed {
    logic [7:0]  mx;
    logic        gray;
    sector_e     sector;
    logic        neg;
    logic [8:0]  sat_div;
    logic [8:0]  sat_rem;
    logic [15:0] sat_low;
    logic [15:0] sat_quo;
    logic [8:0]  hue_div;
    logic [8:0]  hue_rem;
    logic [11:0] hue_low;
    logic [11:0] hue_quo;
  } stage_t;

  // One restoring division step: shift in a bit, subtract if it fits.
  // Returns the quotient bit over the new remainder.
  function automatic logic [9:0] div_step(input logic [8:0] rem, input logic bit_in,
                                          input logic [8:0] div);
    logic [9:0] t;
    logic [9:0] r;
    t = {rem, bit_in};
    if (t >= {1'b0, div}) begin
      r = t - {1'b0, div};
      div_step = {1'b1, r[8:0]};
    end else begin
      div_step = {1'b0, t[8:0]};
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/rhc_front.sv
// Front part: takes pixels, finds max, min and the hue sector, and writes the queue.
// Depends on rhc_pkg.
`default_nettype none

module rhc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire rhc_pkg::pix_t   pix_i,
  input  wire rhc_pkg::q_stat_t q_stat_i,
  output logic                 q_wr_o,
  output rhc_pkg::cls_t        q_data_o
);
  import rhc_pkg::*;

  logic       f_valid_q, f_valid_d;
  pix_t       f_pix_q;
  logic       accept;
  logic [7:0] mx, mn, op_a, op_b;
  sector_e    sector;

  // The input register is free when empty or when its item moves on.
  assign full   = f_valid_q && q_stat_i.full;
  assign accept = push && !full;
  assign q_wr_o = f_valid_q && !q_stat_i.full;

  always_comb begin
    f_valid_d = f_valid_q;
    if (accept) begin
      f_valid_d = 1'b1;
    end else if (q_wr_o) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_pix_q <= pix_i;
    end
  end

  // Extremes of the three channels.
  always_comb begin
    mx = (f_pix_q.red > f_pix_q.green) ? f_pix_q.red : f_pix_q.green;
    mx = (mx > f_pix_q.blue) ? mx : f_pix_q.blue;
    mn = (f_pix_q.red < f_pix_q.green) ? f_pix_q.red : f_pix_q.green;
    mn = (mn < f_pix_q.blue) ? mn : f_pix_q.blue;
  end

  // Sector choice: red takes ties first, then green.
  always_comb begin
    if (f_pix_q.red == mx) begin
      sector = SEC_RED;
      op_a   = f_pix_q.green;
      op_b   = f_pix_q.blue;
    end else if (f_pix_q.green == mx) begin
      sector = SEC_GREEN;
      op_a   = f_pix_q.blue;
      op_b   = f_pix_q.red;
    end else begin
      sector = SEC_BLUE;
      op_a   = f_pix_q.red;
      op_b   = f_pix_q.green;
    end
  end

  // The hue difference travels as sign and magnitude.
  always_comb begin
    q_data_o.mx     = mx;
    q_data_o.delta  = mx - mn;
    q_data_o.gray   = (mx == mn);
    q_data_o.sector = sector;
    q_data_o.neg    = (op_a < op_b);
    q_data_o.mag    = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
  end

endmodule

`default_nettype wire

FILE: sv/rhc_queue.sv
// Short queue of classified pixels between the front and back parts.
// Depends on rhc_pkg.
`default_nettype none

module rhc_queue #(
  parameter int unsigned Depth = rhc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire rhc_pkg::cls_t    wr_data_i,
  input  wire logic             rd_i,
  output rhc_pkg::cls_t         rd_data_o,
  output rhc_pkg::q_stat_t      stat_o
);
  import rhc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  cls_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == DepthCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign rd_data_o    = mem_q[rd_ptr_q];

  // Pointers wrap at the depth, which need not be a power of two.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // The fill level stays within the depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("queue fill level above depth");

  // A lone write raises the fill level by one.
  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i && !rd_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue fill level missed a write");

  // Nothing is read from an empty queue.
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !stat_o.empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: sv/rhc_back.sv
// Back part: pipelined long division for saturation and hue, hue wrap, result register.
// Depends on rhc_pkg.
`default_nettype none

module rhc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rhc_pkg::q_stat_t q_stat_i,
  input  wire rhc_pkg::cls_t    q_data_i,
  output logic                  q_rd_o,
  output logic                  empty,
  input  wire logic             pop,
  output rhc_pkg::hsv_t         hsv_o
);
  import rhc_pkg::*;

  localparam int unsigned NStages = SAT_STEPS + 1;

  logic        en;
  logic        vld_q [NStages];
  stage_t      stg_q [NStages];
  stage_t      stg_d [NStages];
  logic        out_valid_q;
  hsv_t        out_q, out_d;
  logic [24:0] num_sat;
  logic [20:0] num_hue;
  logic [15:0] base, hue_s;

  // The whole pipeline moves unless a finished result waits unread.
  assign en     = !out_valid_q || pop;
  assign q_rd_o = en && !q_stat_i.empty;
  assign empty  = !out_valid_q;
  assign hsv_o  = out_q;

  // Stage zero: numerators with rounding terms, first remainder bits.
  // Saturation: (2*delta*65535 + max) / (2*max). Hue: (7680*mag + delta) / (2*delta).
  always_comb begin
    num_sat = {q_data_i.delta, 17'b0} - {16'b0, q_data_i.delta, 1'b0}
            + {17'b0, q_data_i.mx};
    num_hue = {q_data_i.mag, 13'b0} - {4'b0, q_data_i.mag, 9'b0}
            + {13'b0, q_data_i.delta};
    stg_d[0].mx      = q_data_i.mx;
    stg_d[0].gray    = q_data_i.gray;
    stg_d[0].sector  = q_data_i.sector;
    stg_d[0].neg     = q_data_i.neg;
    stg_d[0].sat_div = {q_data_i.mx, 1'b0};
    stg_d[0].sat_rem = num_sat[24:16];
    stg_d[0].sat_low = num_sat[15:0];
    stg_d[0].sat_quo = '0;
    stg_d[0].hue_div = {q_data_i.delta, 1'b0};
    stg_d[0].hue_rem = num_hue[20:12];
    stg_d[0].hue_low = num_hue[11:0];
    stg_d[0].hue_quo = '0;
  end

  // Each later stage retires one saturation bit, and one hue bit in the first stages.
  for (genvar k = 1; k < NStages; k++) begin : g_div
    logic [9:0] s_step, h_step;
    assign s_step = div_step(stg_q[k-1].sat_rem, stg_q[k-1].sat_low[15], stg_q[k-1].sat_div);
    assign h_step = div_step(stg_q[k-1].hue_rem, stg_q[k-1].hue_low[11], stg_q[k-1].hue_div);
    always_comb begin
      stg_d[k]         = stg_q[k-1];
      stg_d[k].sat_rem = s_step[8:0];
      stg_d[k].sat_low = {stg_q[k-1].sat_low[14:0], 1'b0};
      stg_d[k].sat_quo = {stg_q[k-1].sat_quo[14:0], s_step[9]};
      if (k <= HUE_STEPS) begin
        stg_d[k].hue_rem = h_step[8:0];
        stg_d[k].hue_low = {stg_q[k-1].hue_low[10:0], 1'b0};
        stg_d[k].hue_quo = {stg_q[k-1].hue_quo[10:0], h_step[9]};
      end
    end
  end

  // Stage registers: valid bits reset, payload does not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NStages; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= q_rd_o;
      for (int i = 1; i < NStages; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_valid_q <= vld_q[NStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NStages; i++) begin
        stg_q[i] <= stg_d[i];
      end
      out_q <= out_d;
    end
  end

  // Hue: sector base plus signed offset, wrapped into one turn.
  always_comb begin
    case (stg_q[NStages-1].sector)
      SEC_RED:   base = BASE_RED;
      SEC_GREEN: base = BASE_GREEN;
      SEC_BLUE:  base = BASE_BLUE;
      default:   base = BASE_RED;
    endcase
    if (stg_q[NStages-1].neg) begin
      hue_s = base - {4'b0, stg_q[NStages-1].hue_quo};
    end else begin
      hue_s = base + {4'b0, stg_q[NStages-1].hue_quo};
    end
    if (hue_s[15]) begin
      hue_s = hue_s + HUE_FULL;
    end else if (hue_s >= HUE_FULL) begin
      hue_s = hue_s - HUE_FULL;
    end
  end

  // A gray pixel has no hue and no saturation.
  always_comb begin
    out_d.brightness = {stg_q[NStages-1].mx, stg_q[NStages-1].mx};
    if (stg_q[NStages-1].gray) begin
      out_d.hue        = '0;
      out_d.saturation = '0;
      out_d.achromatic = 1'b1;
    end else begin
      out_d.hue        = hue_s[14:0];
      out_d.saturation = stg_q[NStages-1].sat_quo;
      out_d.achromatic = 1'b0;
    end
  end

  // A result that waits unread is still there in the next cycle.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> out_valid_q)
    else $error("waiting result dropped");

  // Delivered hue stays below one full turn.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, out_q.hue} < HUE_FULL))
    else $error("hue out of range");

  // A gray result carries zero hue and saturation.
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.achromatic) |-> (out_q.hue == '0 && out_q.saturation == '0))
    else $error("gray result with hue or saturation");

endmodule

`default_nettype wire

FILE: sv/rgb_to_hsv_converter_top.sv
// Top level of the RGB to HSV converter: front classifier, queue, division back end.
// Depends on rhc_pkg, rhc_front, rhc_queue and rhc_back.
//
//   channel  direction  handshake          payload
//   pixel    in         push / full        pix_i (red, green, blue)
//   result   out        pop / empty        hsv_o (hue, saturation, brightness, achromatic)
//
// One pixel is accepted per cycle while full is low, and one result delivered per cycle when pop keeps up.
// A result reaches the outputs through the input register, one queue entry, stage zero,
// sixteen division stages and the result register. The sixteen-stage saturation divider,
// one quotient bit per stage, sets the length of that path.
// While a result waits unread the back end holds; the queue and the input register then
// absorb up to QueueDepth + 1 pixels before full rises. Reset empties every stage at once.
`default_nettype none

module rgb_to_hsv_converter_top #(
  parameter int unsigned QueueDepth = rhc_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire rhc_pkg::pix_t pix_i,
  output logic               empty,
  input  wire logic          pop,
  output rhc_pkg::hsv_t      hsv_o
);
  import rhc_pkg::*;

  q_stat_t q_stat;
  logic    q_wr, q_rd;
  cls_t    q_wr_data, q_rd_data;

  rhc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .pix_i    (pix_i),
    .q_stat_i (q_stat),
    .q_wr_o   (q_wr),
    .q_data_o (q_wr_data)
  );

  rhc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_data),
    .rd_i      (q_rd),
    .rd_data_o (q_rd_data),
    .stat_o    (q_stat)
  );

  rhc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .q_data_i (q_rd_data),
    .q_rd_o   (q_rd),
    .empty    (empty),
    .pop      (pop),
    .hsv_o    (hsv_o)
  );

endmodule

`default_nettype wire
